[hw/rtl/assert_macros.svh]
// Assertion macros shared by the lux to backlight RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked in every cycle, reset included.
`define ASSERT_RESET(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("reset assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_RESET(lbl, clk, prop)
`endif
`endif

[hw/rtl/lbc_pkg.sv]
// Types and constants of the lux to backlight lightness curve.
`default_nettype none
package lbc_pkg;

  localparam int Q_BITS = 24;
  localparam logic [24:0] Q_ONE = 25'(1) << Q_BITS;

  // Normalisation Y = floor(lux * 2^24 / 10000)
  localparam logic [13:0] LUX_FULL   = 14'd10000;
  localparam int          NORM_SHIFT = 14;
  localparam logic [24:0] NORM_RECIP = 25'd27487790;   // floor(2^38 / 10000)

  // Linear toe of the curve
  localparam logic [24:0] LIN_LIMIT = 25'd148579;
  localparam logic [13:0] LIN_GAIN  = 14'd9033;

  // Cube-root part: (116 * c - 16 * 2^24) / 100, worked as * 10 / 1000
  localparam int          ROOT_STEPS  = 25;
  localparam logic [6:0]  CUBE_GAIN   = 7'd116;
  localparam logic [31:0] CUBE_OFFSET = 32'd16 << Q_BITS;
  localparam logic [3:0]  CUBE_SCALE  = 4'd10;

  // Shared divide by 1000
  localparam logic [9:0]  DIV_DEN   = 10'd1000;
  localparam int          DIV_SHIFT = 35;
  localparam logic [25:0] DIV_RECIP = 26'd34359738;   // floor(2^35 / 1000)

  // Register indexes
  localparam logic [1:0] REG_MIN_LEVEL  = 2'd0;
  localparam logic [1:0] REG_MAX_LEVEL  = 2'd1;
  localparam logic [1:0] REG_FAIL_LEVEL = 2'd2;

  typedef struct packed {
    logic [7:0] min_level;
    logic [7:0] max_level;
    logic [7:0] fail_level;
  } cfg_t;

  typedef struct packed {
    logic        fail;
    logic [24:0] y;
  } y_item_t;

  typedef struct packed {
    logic        fail;
    logic [24:0] y;
    logic [24:0] c;
  } root_item_t;

endpackage
`default_nettype wire

[hw/rtl/lbc_norm.sv]
// Clamp of the lux reading and normalisation to Q24, three stages.
`default_nettype none
`include "assert_macros.svh"
module lbc_norm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire logic [15:0]     lux,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output lbc_pkg::y_item_t     dn_item
);
  import lbc_pkg::*;

  logic [2:0]  v;
  logic [2:0]  en;
  logic        fail1, fail2;
  logic [13:0] lux1, lux2;
  logic [24:0] q2;
  logic [13:0] luxc;
  logic [38:0] prod1;
  logic [37:0] prod2;
  logic [37:0] rem;
  logic [24:0] y_next;

  assign en[2] = !v[2] || dn_ready;
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];
  assign up_ready = en[0];

  assign luxc   = (lux[14:0] > {1'b0, LUX_FULL}) ? LUX_FULL : lux[13:0];
  assign prod1  = 39'(lux1) * 39'(NORM_RECIP);
  assign prod2  = 38'(q2) * 38'(LUX_FULL);
  assign rem    = {lux2, 24'b0} - prod2;
  // estimate is exact or one low
  assign y_next = q2 + 25'(rem >= 38'(LUX_FULL));

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && up_valid) begin
      fail1 <= lux[15];
      lux1  <= luxc;
    end
    if (en[1] && v[0]) begin
      fail2 <= fail1;
      lux2  <= lux1;
      q2    <= prod1[38:NORM_SHIFT];
    end
    if (en[2] && v[1]) begin
      dn_item.fail <= fail2;
      dn_item.y    <= y_next;
    end
  end

  assign dn_valid = v[2];

  `ASSERT_PROP(a_y_in_range, clk, rst, (dn_valid && !dn_item.fail) |-> (dn_item.y <= Q_ONE))

endmodule
`default_nettype wire

[hw/rtl/lbc_cbrt.sv]
// Bit-serial exact cube root of Y * 2^48, one result bit per stage.
`default_nettype none
`include "assert_macros.svh"
module lbc_cbrt (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire lbc_pkg::y_item_t  up_item,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output lbc_pkg::root_item_t    dn_item
);
  import lbc_pkg::*;

  localparam int LAST = ROOT_STEPS - 1;

  // running root with its exact square and cube
  typedef struct packed {
    logic        fail;
    logic [24:0] y;
    logic [24:0] c;
    logic [48:0] c2;
    logic [72:0] c3;
  } cb_t;

  cb_t               stage_in [ROOT_STEPS];
  cb_t               stage_q  [ROOT_STEPS];
  logic [LAST:0]     vin;
  logic [LAST:0]     v;
  logic [LAST:0]     en;

  assign stage_in[0] = '{fail: up_item.fail, y: up_item.y, c: '0, c2: '0, c3: '0};
  assign vin[0]      = up_valid;
  assign en[LAST]    = !v[LAST] || dn_ready;
  assign up_ready    = en[0];

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
    localparam int B = LAST - i;
    logic [75:0] cand;
    logic [75:0] target;
    logic        fit;
    cb_t         nxt;

    if (i > 0) begin : g_link
      assign stage_in[i] = stage_q[i-1];
      assign vin[i]      = v[i-1];
    end
    if (i < LAST) begin : g_en
      assign en[i] = !v[i] || en[i+1];
    end

    // (c + 2^B)^3 = c^3 + 3 c^2 2^B + 3 c 2^2B + 2^3B
    assign cand = 76'(stage_in[i].c3)
                + ((76'(stage_in[i].c2) + (76'(stage_in[i].c2) << 1)) << B)
                + ((76'(stage_in[i].c) + (76'(stage_in[i].c) << 1)) << (2 * B))
                + (76'(1) << (3 * B));
    assign target = {3'b0, stage_in[i].y, 48'b0};
    assign fit    = cand <= target;

    always_comb begin
      nxt = stage_in[i];
      if (fit) begin
        nxt.c  = stage_in[i].c | (25'(1) << B);
        nxt.c2 = stage_in[i].c2 + (49'(stage_in[i].c) << (B + 1)) + (49'(1) << (2 * B));
        nxt.c3 = cand[72:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= vin[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en[i] && vin[i]) begin
        stage_q[i] <= nxt;
      end
    end
  end

  assign dn_valid     = v[LAST];
  assign dn_item.fail = stage_q[LAST].fail;
  assign dn_item.y    = stage_q[LAST].y;
  assign dn_item.c    = stage_q[LAST].c;

  `ASSERT_PROP(a_root_fits, clk, rst, v[LAST] |-> (stage_q[LAST].c3 <= {stage_q[LAST].y, 48'b0}))

endmodule
`default_nettype wire

[hw/rtl/lbc_map.sv]
// Lightness from Y or its cube root, divide by 1000, map onto the duty range.
`default_nettype none
`include "assert_macros.svh"
module lbc_map (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lbc_pkg::cfg_t       cfg,
  input  wire logic                up_valid,
  output logic                     up_ready,
  input  wire lbc_pkg::root_item_t up_item,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output logic [7:0]               duty
);
  import lbc_pkg::*;

  logic [3:0]  v;
  logic [3:0]  en;
  logic        fail1, fail2, fail3, fail4;
  logic [34:0] n1, n2;
  logic [25:0] q2;
  logic [24:0] p3;

  logic        lin;
  logic [34:0] n_lin;
  logic [31:0] a_cube;
  logic [31:0] num_cube;
  logic [34:0] n_cube;
  logic [60:0] prod_q;
  logic [34:0] rem;
  logic [25:0] p_raw;
  logic [24:0] p_sat;
  logic [7:0]  span;
  logic [32:0] prod_d;

  assign en[3] = !v[3] || dn_ready;
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign en[0] = !v[0] || en[1];
  assign up_ready = en[0];

  // stage 1: numerator over 1000 for either branch
  assign lin      = up_item.y <= LIN_LIMIT;
  assign n_lin    = 35'(up_item.y[17:0]) * 35'(LIN_GAIN);
  assign a_cube   = 32'(up_item.c) * 32'(CUBE_GAIN);
  assign num_cube = (a_cube > CUBE_OFFSET) ? (a_cube - CUBE_OFFSET) : '0;
  assign n_cube   = 35'(num_cube) * 35'(CUBE_SCALE);

  // stage 2/3: reciprocal estimate, then a single correction
  assign prod_q = 61'(n1) * 61'(DIV_RECIP);
  assign rem    = n2 - 35'(q2) * 35'(DIV_DEN);
  assign p_raw  = q2 + 26'(rem >= 35'(DIV_DEN));
  assign p_sat  = (p_raw > 26'(Q_ONE)) ? Q_ONE : p_raw[24:0];

  // stage 4: linear map
  assign span   = (cfg.max_level >= cfg.min_level) ? (cfg.max_level - cfg.min_level) : '0;
  assign prod_d = 33'(p3) * 33'(span);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && up_valid) begin
      fail1 <= up_item.fail;
      n1    <= lin ? n_lin : n_cube;
    end
    if (en[1] && v[0]) begin
      fail2 <= fail1;
      n2    <= n1;
      q2    <= prod_q[60:DIV_SHIFT];
    end
    if (en[2] && v[1]) begin
      fail3 <= fail2;
      p3    <= p_sat;
    end
    if (en[3] && v[2]) begin
      fail4 <= fail3;
      duty  <= fail3 ? cfg.fail_level : (cfg.min_level + prod_d[31:24]);
    end
  end

  assign dn_valid = v[3];

  `ASSERT_PROP(a_duty_in_range, clk, rst, (v[3] && !fail4 && cfg.max_level >= cfg.min_level) |-> (duty >= cfg.min_level && duty <= cfg.max_level))

endmodule
`default_nettype wire

[hw/rtl/lux_to_backlight_cie_curve.sv]
// Top level: lux reading to backlight duty on the CIE 1931 lightness curve.
//
// Input channel in_valid/in_ready carries one signed lux request; the output
// channel out_valid/out_ready returns one duty value per request, in order.
// Negative lux gives fail_level; otherwise lux is clamped to 10000, turned
// into lightness (linear toe, cube root above it) and mapped onto
// min_level..max_level (span zero if max_level < min_level).
// The pipe is normalisation, then the bit-serial cube root (one bit per stage),
// then the divide and duty map.
// Throughput is one request per cycle; every stage is a register with its
// own valid bit, so bubbles close up when the receiver stalls and requests
// keep being taken until the pipe is full. A stall loses nothing.
// Registers sit on an APB-style port at byte addresses 0 (min_level),
// 4 (max_level) and 8 (fail_level), paddr[1:0] ignored; pready is tied high,
// addresses 12 to 15 read as zero and ignore writes. Registers are read
// live by the last stage, so write them only while the pipe is empty.
// Reset (synchronous, active high) empties the pipe and loads 15/255/128.
`default_nettype none
`include "assert_macros.svh"
module lux_to_backlight_cie_curve (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] lux,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       duty,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lbc_pkg::*;

  cfg_t        cfg;
  logic        cfg_wr;
  logic [1:0]  reg_idx;

  y_item_t     norm_item;
  logic        norm_valid, norm_ready;
  root_item_t  root_item;
  logic        root_valid, root_ready;

  // ---- register port ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_level  <= 8'd15;
      cfg.max_level  <= 8'd255;
      cfg.fail_level <= 8'd128;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MIN_LEVEL:  cfg.min_level  <= pwdata[7:0];
        REG_MAX_LEVEL:  cfg.max_level  <= pwdata[7:0];
        REG_FAIL_LEVEL: cfg.fail_level <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_LEVEL:  prdata = {24'b0, cfg.min_level};
      REG_MAX_LEVEL:  prdata = {24'b0, cfg.max_level};
      REG_FAIL_LEVEL: prdata = {24'b0, cfg.fail_level};
      default:        prdata = '0;
    endcase
  end

  // ---- datapath: normalise -> cube root -> map ----
  lbc_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .lux      (lux),
    .dn_valid (norm_valid),
    .dn_ready (norm_ready),
    .dn_item  (norm_item)
  );

  lbc_cbrt u_cbrt (
    .clk      (clk),
    .rst      (rst),
    .up_valid (norm_valid),
    .up_ready (norm_ready),
    .up_item  (norm_item),
    .dn_valid (root_valid),
    .dn_ready (root_ready),
    .dn_item  (root_item)
  );

  lbc_map u_map (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (root_valid),
    .up_ready (root_ready),
    .up_item  (root_item),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .duty     (duty)
  );

  `ASSERT_PROP(a_cfg_min_write, clk, rst, (cfg_wr && reg_idx == REG_MIN_LEVEL) |=> (cfg.min_level == $past(pwdata[7:0])))
  `ASSERT_RESET(a_reset_empties, clk, rst |=> !out_valid)

endmodule
`default_nettype wire
